[hw/rtl/bmpu_pkg.sv]
// bmpu_pkg: shared types and constants for the 24-bit bmp stream unpacker
`timescale 1ns / 1ps
`default_nettype none

package bmpu_pkg;

    // parser phases
    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PIXELS,
        PH_PAD,
        PH_DONE
    } phase_t;

    // result status codes
    localparam logic [1:0] ST_PIXEL     = 2'd0;
    localparam logic [1:0] ST_BAD_DEPTH = 2'd1;
    localparam logic [1:0] ST_BAD_SIZE  = 2'd2;

    // header layout
    localparam logic [5:0]  HEADER_LAST = 6'd53;
    localparam logic [5:0]  WIDTH_OFS   = 6'd18;
    localparam logic [5:0]  HEIGHT_OFS  = 6'd22;
    localparam logic [5:0]  DEPTH_OFS   = 6'd28;
    localparam logic [15:0] DEPTH_24    = 16'd24;

    // triple positions within a pixel
    localparam logic [1:0] POS_BLUE  = 2'd0;
    localparam logic [1:0] POS_GREEN = 2'd1;
    localparam logic [1:0] POS_RED   = 2'd2;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [11:0] column;
        logic [11:0] row;
        logic        last_pixel;
        logic [1:0]  status;
    } pixel_t;

endpackage

`default_nettype wire

[hw/rtl/bmpu_if.sv]
// bmpu_if: valid/ready channel interfaces for the byte input and pixel output
`timescale 1ns / 1ps
`default_nettype none

interface bmpu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;

    modport source (output valid, output data_byte, output first_byte, input ready);
    modport sink   (input valid, input data_byte, input first_byte, output ready);
endinterface

interface bmpu_pixel_if;
    logic              valid;
    logic              ready;
    bmpu_pkg::pixel_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[hw/rtl/bmp24_stream_unpacker.sv]
// bmp24_stream_unpacker: byte-serial decoder of 24-bit bgr bmp files
//
// usage
//   stream: one file byte per item; first_byte restarts the parser and the
//     byte is taken as header byte 0
//   pixel: one item per complete blue/green/red triple with column and row,
//     last_pixel on the final pixel; a bad depth or size gives one item
//     with status set and all other fields zero
// timing
//   one byte per cycle while stream.ready is high; the parser state is a set of
//   counters updated in the accepting cycle and the result sits in one output
//   register, visible the cycle after the red byte is accepted
//   stream.ready is high while the output register is empty or being taken
// reset
//   rst_n clears the parser to the header phase and empties the output;
//   the first byte after reset is header byte 0 even without first_byte
// stall
//   a held result blocks new bytes only while pixel.ready stays low
//   header, pad and trailing bytes still need the output register free
`timescale 1ns / 1ps
`default_nettype none

module bmp24_stream_unpacker #(
    parameter int MAX_DIM = 4096
) (
    input  wire          clk,
    input  wire          rst_n,
    bmpu_byte_if.sink    stream,
    bmpu_pixel_if.source pixel
);
    import bmpu_pkg::*;

    // column and row counts never reach MAX_DIM
    localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // parser control state
    phase_t             phase_reg, phase_next;
    logic [5:0]         hdr_cnt_reg, hdr_cnt_next;
    logic [1:0]         pos_reg, pos_next;
    logic [CNT_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   row_reg, row_next;
    logic [1:0]         pad_reg, pad_next;

    // captured header fields and held components
    logic [31:0]        width_reg, width_next;
    logic [31:0]        height_reg, height_next;
    logic [15:0]        depth_reg, depth_next;
    logic [7:0]         blue_reg, blue_next;
    logic [7:0]         green_reg, green_next;

    // output register
    logic               ovalid_reg, ovalid_next;
    pixel_t             odata_reg, odata_next;

    logic               accept;
    logic               emit;
    pixel_t             result;
    logic [1:0]         lane_ofs;

    assign stream.ready = !ovalid_reg || pixel.ready;
    assign accept       = stream.valid && stream.ready;
    assign pixel.valid  = ovalid_reg;
    assign pixel.data   = odata_reg;

    always_comb
    begin
        phase_next  = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        pos_next    = pos_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        pad_next    = pad_reg;
        width_next  = width_reg;
        height_next = height_reg;
        depth_next  = depth_reg;
        blue_next   = blue_reg;
        green_next  = green_reg;
        emit        = 1'b0;
        result      = '0;
        lane_ofs    = '0;

        // a new file restarts the parser before this byte is looked at
        if (stream.first_byte)
        begin
            phase_next   = PH_HEADER;
            hdr_cnt_next = '0;
            pos_next     = POS_BLUE;
            col_next     = '0;
            row_next     = '0;
            pad_next     = '0;
        end

        case (phase_next)
            PH_HEADER:
            begin
                // each header lane is written exactly once per file
                if (hdr_cnt_next >= WIDTH_OFS && hdr_cnt_next < WIDTH_OFS + 6'd4)
                begin
                    lane_ofs = 2'(hdr_cnt_next - WIDTH_OFS);
                    width_next[8*lane_ofs +: 8] = stream.data_byte;
                end
                else if (hdr_cnt_next >= HEIGHT_OFS && hdr_cnt_next < HEIGHT_OFS + 6'd4)
                begin
                    lane_ofs = 2'(hdr_cnt_next - HEIGHT_OFS);
                    height_next[8*lane_ofs +: 8] = stream.data_byte;
                end
                else if (hdr_cnt_next >= DEPTH_OFS && hdr_cnt_next < DEPTH_OFS + 6'd2)
                begin
                    lane_ofs = 2'(hdr_cnt_next - DEPTH_OFS);
                    depth_next[8*lane_ofs[0] +: 8] = stream.data_byte;
                end

                if (hdr_cnt_next != HEADER_LAST)
                begin
                    hdr_cnt_next = hdr_cnt_next + 6'd1;
                end
                else
                begin
                    hdr_cnt_next = '0;
                    if (depth_reg != DEPTH_24)
                    begin
                        phase_next    = PH_DONE;
                        emit          = 1'b1;
                        result.status = ST_BAD_DEPTH;
                    end
                    else if (width_reg == '0 || height_reg == '0
                             || width_reg > 32'(MAX_DIM) || height_reg > 32'(MAX_DIM))
                    begin
                        phase_next    = PH_DONE;
                        emit          = 1'b1;
                        result.status = ST_BAD_SIZE;
                    end
                    else
                    begin
                        phase_next = PH_PIXELS;
                    end
                end
            end

            PH_PAD:
            begin
                // pad count is nonzero on entry
                pad_next = pad_next - 2'd1;
                if (pad_next == 2'd0)
                begin
                    phase_next = PH_PIXELS;
                end
            end

            PH_PIXELS:
            begin
                if (pos_next == POS_BLUE)
                begin
                    blue_next = stream.data_byte;
                    pos_next  = POS_GREEN;
                end
                else if (pos_next == POS_GREEN)
                begin
                    green_next = stream.data_byte;
                    pos_next   = POS_RED;
                end
                else
                begin
                    emit              = 1'b1;
                    result.red        = stream.data_byte;
                    result.green      = green_reg;
                    result.blue       = blue_reg;
                    result.column     = 12'(col_next);
                    result.row        = 12'(row_next);
                    result.status     = ST_PIXEL;
                    pos_next          = POS_BLUE;
                    if (32'(col_next) + 32'd1 >= width_reg)
                    begin
                        // end of row
                        col_next = '0;
                        if (32'(row_next) + 32'd1 >= height_reg)
                        begin
                            result.last_pixel = 1'b1;
                            phase_next        = PH_DONE;
                        end
                        else
                        begin
                            row_next = row_next + CNT_W'(1);
                            pad_next = width_reg[1:0];
                            if (width_reg[1:0] != 2'd0)
                            begin
                                phase_next = PH_PAD;
                            end
                        end
                    end
                    else
                    begin
                        col_next = col_next + CNT_W'(1);
                    end
                end
            end

            default:
            begin
                // done: trailing bytes are dropped
            end
        endcase
    end

    always_comb
    begin
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        if (accept)
        begin
            ovalid_next = emit;
            odata_next  = result;
        end
        else if (pixel.ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HEADER;
            hdr_cnt_reg <= '0;
            pos_reg     <= POS_BLUE;
            col_reg     <= '0;
            row_reg     <= '0;
            pad_reg     <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
            if (accept)
            begin
                phase_reg   <= phase_next;
                hdr_cnt_reg <= hdr_cnt_next;
                pos_reg     <= pos_next;
                col_reg     <= col_next;
                row_reg     <= row_next;
                pad_reg     <= pad_next;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        if (accept)
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            depth_reg  <= depth_next;
            blue_reg   <= blue_next;
            green_reg  <= green_next;
        end
    end

endmodule

`default_nettype wire

[bench/bmp24_stream_unpacker_tb.sv]
// bmp24_stream_unpacker_tb: self-checking bench for the 24-bit bmp stream unpacker
`timescale 1ns / 1ps

module bmp24_stream_unpacker_tb;
    import bmpu_pkg::*;

    localparam logic [31:0] SIZE_LIMIT     = 32'd4096;
    localparam int          WATCHDOG_LIMIT = 1000;
    localparam int          RANDOM_BYTES   = 120;
    localparam int          MAX_REPORTS    = 10;

    logic clk;
    logic rst_n;

    bmpu_byte_if  stream_ch ();
    bmpu_pixel_if pixel_ch ();

    bmp24_stream_unpacker #(
        .MAX_DIM(SIZE_LIMIT)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .stream(stream_ch),
        .pixel (pixel_ch)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // pixels the decoder still owes us, oldest first
    pixel_t pending_pixels[$];

    int err_count  = 0;
    int file_bytes = 0;
    int gap_odds   = 0;      // 0: sender never pauses
    int stall_odds = 0;      // 0: receiver never stalls
    bit quiet_tail = 1'b0;   // no idling on either side at the end of the run

    // shadow of the parser
    phase_t      parse_phase;
    logic [5:0]  hdr_index;
    logic [31:0] img_width;
    logic [31:0] img_height;
    logic [15:0] img_depth;
    logic [1:0]  triple_pos;
    logic [7:0]  blue_byte;
    logic [7:0]  green_byte;
    logic [31:0] col_index;
    logic [31:0] row_index;
    logic [1:0]  pad_left;

    function automatic void clear_parser();
        parse_phase = PH_HEADER;
        hdr_index   = '0;
        img_width   = '0;
        img_height  = '0;
        img_depth   = '0;
        triple_pos  = POS_BLUE;
        blue_byte   = '0;
        green_byte  = '0;
        col_index   = '0;
        row_index   = '0;
        pad_left    = '0;
    endfunction

    // advance the shadow parser by one byte; returns 1 when a pixel or error comes out
    function automatic bit unpack_byte(input logic [7:0] in_byte, input logic restart,
                                       output pixel_t res);
        res = '0;
        if (restart)
            clear_parser();
        case (parse_phase)
            PH_HEADER:
            begin
                if (hdr_index >= WIDTH_OFS && hdr_index < WIDTH_OFS + 6'd4)
                    img_width |= {24'd0, in_byte} << (8 * (hdr_index - WIDTH_OFS));
                else if (hdr_index >= HEIGHT_OFS && hdr_index < HEIGHT_OFS + 6'd4)
                    img_height |= {24'd0, in_byte} << (8 * (hdr_index - HEIGHT_OFS));
                else if (hdr_index >= DEPTH_OFS && hdr_index < DEPTH_OFS + 6'd2)
                    img_depth |= {8'd0, in_byte} << (8 * (hdr_index - DEPTH_OFS));
                if (hdr_index != HEADER_LAST)
                begin
                    hdr_index++;
                    return 1'b0;
                end
                hdr_index = '0;
                if (img_depth != DEPTH_24)
                begin
                    parse_phase = PH_DONE;
                    res.status  = ST_BAD_DEPTH;
                    return 1'b1;
                end
                if (img_width == 0 || img_height == 0 ||
                    img_width > SIZE_LIMIT || img_height > SIZE_LIMIT)
                begin
                    parse_phase = PH_DONE;
                    res.status  = ST_BAD_SIZE;
                    return 1'b1;
                end
                parse_phase = PH_PIXELS;
                return 1'b0;
            end
            PH_PAD:
            begin
                if (pad_left != 0)
                    pad_left--;
                if (pad_left == 0)
                    parse_phase = PH_PIXELS;
                return 1'b0;
            end
            PH_PIXELS:
            begin
                if (triple_pos == POS_BLUE)
                begin
                    blue_byte  = in_byte;
                    triple_pos = POS_GREEN;
                    return 1'b0;
                end
                if (triple_pos == POS_GREEN)
                begin
                    green_byte = in_byte;
                    triple_pos = POS_RED;
                    return 1'b0;
                end
                // red byte closes the triple
                res.red    = in_byte;
                res.green  = green_byte;
                res.blue   = blue_byte;
                res.column = col_index[11:0];
                res.row    = row_index[11:0];
                res.status = ST_PIXEL;
                triple_pos = POS_BLUE;
                if (col_index + 32'd1 >= img_width)
                begin
                    col_index = '0;
                    if (row_index + 32'd1 >= img_height)
                    begin
                        res.last_pixel = 1'b1;
                        parse_phase    = PH_DONE;
                    end
                    else
                    begin
                        row_index++;
                        pad_left = img_width[1:0];
                        if (pad_left != 0)
                            parse_phase = PH_PAD;
                    end
                end
                else
                    col_index++;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    function automatic int image_bytes(input int w, input int h);
        return h * (3 * w + w % 4);
    endfunction

    task automatic note_failure(input string what, input pixel_t want, input pixel_t got);
        err_count++;
        if (err_count <= MAX_REPORTS)
        begin
            $display("%s: expected r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d st=%0d",
                     what, want.red, want.green, want.blue, want.column, want.row,
                     want.last_pixel, want.status);
            $display("    actual r=%0d g=%0d b=%0d col=%0d row=%0d last=%0d st=%0d",
                     got.red, got.green, got.blue, got.column, got.row,
                     got.last_pixel, got.status);
        end
    endtask

    // one byte onto the stream; returns at the edge where it was taken
    task automatic send_byte(input logic [7:0] value, input logic restart);
        pixel_t res;
        if (gap_odds != 0 && !quiet_tail && $urandom_range(1, gap_odds) == 1)
        begin
            stream_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        stream_ch.valid      <= 1'b1;
        stream_ch.data_byte  <= value;
        stream_ch.first_byte <= restart;
        @(posedge clk);
        while (!stream_ch.ready)
            @(posedge clk);
        if (unpack_byte(value, restart, res))
            pending_pixels.push_back(res);
    endtask

    // header with random filler around the size and depth fields, then body_len random bytes
    task automatic send_file(input logic [31:0] w, input logic [31:0] h, input logic [15:0] bits,
                             input int body_len, input bit with_first);
        logic [7:0] hdr [0:53];
        for (int i = 0; i < 54; i++)
            hdr[i] = 8'($urandom);
        for (int k = 0; k < 4; k++)
        begin
            hdr[int'(WIDTH_OFS) + k]  = w[8*k +: 8];
            hdr[int'(HEIGHT_OFS) + k] = h[8*k +: 8];
        end
        hdr[int'(DEPTH_OFS)]     = bits[7:0];
        hdr[int'(DEPTH_OFS) + 1] = bits[15:8];
        for (int i = 0; i < 54; i++)
            send_byte(hdr[i], with_first && i == 0);
        for (int i = 0; i < body_len; i++)
            send_byte(8'($urandom), 1'b0);
        file_bytes += 54 + body_len;
    endtask

    task automatic drain_results();
        stream_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    // parser must start at header byte 0 after reset without the first flag
    task automatic test_no_first_flag();
        send_file(3, 2, DEPTH_24, image_bytes(3, 2) + 4, 1'b0);
    endtask

    task automatic test_bad_depth();
        send_file(2, 2, 16'h0118, 3, 1'b1);   // low byte alone looks like 24
        send_file(1, 1, 16'hFFFF, 0, 1'b1);
    endtask

    task automatic test_bad_size();
        send_file(0, 3, DEPTH_24, 2, 1'b1);
        send_file(SIZE_LIMIT + 1, 1, DEPTH_24, 2, 1'b1);
        send_file(2, 32'hFFFF_FFFE, DEPTH_24, 2, 1'b1);   // top-down file, negative height
    endtask

    task automatic test_size_limits();
        send_file(1, 1, DEPTH_24, image_bytes(1, 1) + 2, 1'b1);
        // largest legal size, cut short after a few pixels
        send_file(SIZE_LIMIT, SIZE_LIMIT, DEPTH_24, 14, 1'b1);
    endtask

    task automatic test_restart();
        send_byte(8'($urandom), 1'b1);
        for (int i = 0; i < 20; i++)
            send_byte(8'($urandom), 1'b0);
        send_file(5, 2, DEPTH_24, 7, 1'b1);       // stops inside a triple
    endtask

    task automatic test_pressure();
        gap_odds   = 4;
        stall_odds = 3;
        send_file(4, 2, DEPTH_24, image_bytes(4, 2), 1'b1);
        drain_results();
        send_file(2, 1, DEPTH_24, image_bytes(2, 1) + 3, 1'b1);
    endtask

    task automatic test_random_files();
        int          first_mark;
        int          kind;
        int          w;
        int          h;
        logic [31:0] big_w;
        logic [31:0] big_h;
        first_mark = file_bytes;
        while (file_bytes < first_mark + RANDOM_BYTES)
        begin
            if (file_bytes > first_mark + RANDOM_BYTES * 3 / 4)
                quiet_tail = 1'b1;
            gap_odds   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            stall_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 8);
            kind = $urandom_range(0, 19);
            w    = $urandom_range(1, 7);
            h    = $urandom_range(1, 3);
            if (kind <= 13)
                send_file(w, h, DEPTH_24, image_bytes(w, h) + $urandom_range(0, 3), 1'b1);
            else if (kind <= 15)
                send_file(w, h, DEPTH_24, $urandom_range(0, image_bytes(w, h) - 1), 1'b1);
            else if (kind == 16)
                send_file(w, h, 16'($urandom), $urandom_range(0, 3), 1'b1);
            else if (kind == 17)
            begin
                big_w = w;
                big_h = h;
                case ($urandom_range(0, 3))
                    0: big_w = 0;
                    1: big_h = 0;
                    2: big_w = $urandom_range(SIZE_LIMIT + 1, 32'hFFFF_FFFF);
                    default: big_h = 32'hFFFF_FFFF - $urandom_range(0, 1000);
                endcase
                send_file(big_w, big_h, DEPTH_24, $urandom_range(0, 3), 1'b1);
            end
            else
            begin
                // stray bytes, now and then with a restart mixed in
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // receiver: random stall bursts
    initial
    begin
        int hold;
        hold = 0;
        pixel_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
                hold--;
            else if (stall_odds != 0 && !quiet_tail && $urandom_range(1, stall_odds) == 1)
            begin
                pixel_ch.ready <= 1'b0;
                hold = $urandom_range(1, 11) - 1;
            end
            else
                pixel_ch.ready <= 1'b1;
        end
    end

    // compare every accepted pixel against the oldest prediction
    always @(posedge clk)
    begin
        pixel_t want;
        pixel_t got;
        if (rst_n && pixel_ch.valid && pixel_ch.ready)
        begin
            got = pixel_ch.data;
            if (pending_pixels.size() == 0)
                note_failure("unexpected pixel", '0, got);
            else
            begin
                want = pending_pixels.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.column !== want.column ||
                    got.row !== want.row || got.last_pixel !== want.last_pixel ||
                    got.status !== want.status)
                    note_failure("pixel mismatch", want, got);
            end
        end
    end

    // ends the run if nothing is accepted on either channel for too long
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((stream_ch.valid && stream_ch.ready) || (pixel_ch.valid && pixel_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("bmp24_stream_unpacker_tb: FAIL");
        $finish;
    end

    initial
    begin
        pixel_t blank;
        blank = '0;
        clear_parser();
        rst_n                <= 1'b0;
        stream_ch.valid      <= 1'b0;
        stream_ch.data_byte  <= 8'd0;
        stream_ch.first_byte <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_no_first_flag();
        gap_odds   = 3;
        stall_odds = 3;
        test_bad_depth();
        test_bad_size();
        test_size_limits();
        test_restart();
        test_pressure();
        test_random_files();

        stream_ch.valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (pending_pixels.size() != 0)
            note_failure("pixel never arrived", pending_pixels[0], blank);
        if (err_count == 0)
            $display("bmp24_stream_unpacker_tb: PASS");
        else
            $display("bmp24_stream_unpacker_tb: FAIL");
        $finish;
    end

endmodule
